/* hw/rtl/assert_macros.svh */
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sobel_pkg.sv */
// Types and constants of the Sobel edge block.
`timescale 1ns / 1ps
`default_nettype none

package sobel_pkg;

    localparam int CFG_DW = 11;
    localparam int MAG_W  = 22;

    localparam logic [CFG_DW-1:0] CFG_RESET = 11'd1024;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // 255 squared
    localparam logic [15:0] NORM_SCALE = 16'd65025;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_sample;
    } t_in;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       last_pixel;
    } t_out;

endpackage

`default_nettype wire

/* hw/rtl/sobel_edge_max_normalize.sv */
// Sobel edge magnitude with frame-maximum normalization, top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+---------------------------
// item in   | i_start, o_busy, i_item                   | taken when start & !busy
// result    | o_done, o_result                          | one-cycle strobe, no stall
// config    | i_cfg_valid, o_cfg_ready, i_cfg_index/data | taken when valid & ready
//
// Load item: merge the sample into the line memory and read the window columns in
//   S_LRD1 to S_LRD3, then check each of the four candidate pixels in S_TASK and
//   square and store each one finished (0 to 4 of them) in S_SQ and S_WR.
// Drain item: magnitude memory read at the accept edge, scaling in S_DRD, then a
//   square, multiply and compare step per bit of the square-root search (8 bits);
//   result strobe in the cycle after the last compare. Ignored items leave it idle.
// Reset is synchronous; the line memory needs no clearing pass since only
//   columns written in the current frame are ever read. Results cannot be held.
module sobel_edge_max_normalize #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    output logic                         o_busy,
    input  sobel_pkg::t_in               i_item,
    output logic                         o_done,
    output sobel_pkg::t_out              o_result,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire                          i_cfg_index,
    input  wire [sobel_pkg::CFG_DW-1:0]  i_cfg_data
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = WW + HW;
    localparam int MW    = sobel_pkg::MAG_W;
    localparam int RW    = MW + 16;

    typedef enum logic [3:0] {
        S_IDLE, S_LRD1, S_LRD2, S_LRD3, S_TASK, S_SQ, S_WR,
        S_DRD, S_NSQ, S_NMUL, S_NCMP
    } t_state;

    // the four pixels a load can finish, by center position
    typedef enum logic [1:0] {
        T_UP_LEFT, T_UP_HERE, T_ROW_LEFT, T_ROW_HERE
    } t_task;

    // memories: line columns hold one byte per row slot
    logic [23:0]   line_mem [MAX_WIDTH];
    logic [MW-1:0] mag_mem  [DEPTH];

    t_state                  r_state;
    t_task                   r_task;
    logic [sobel_pkg::CFG_DW-1:0] r_cfg_w, r_cfg_h;
    logic [HW-1:0]           r_lrow, r_row;
    logic [WW-1:0]           r_lcol, r_col;
    logic [1:0]              r_slot, r_slotc;
    logic [AW-1:0]           r_didx, r_idx;
    logic [MW-1:0]           r_max, r_mx, r_mag, r_mag_q;
    logic [7:0]              r_sample, r_v;
    logic [23:0]             r_line_q, r_w0, r_w1, r_w2;
    logic signed [10:0]      r_gx, r_gy;
    logic [15:0]             r_sq;
    logic [RW-1:0]           r_prod, r_rhs;
    logic [2:0]              r_nb;
    logic                    r_last, r_done;
    sobel_pkg::t_out         r_out;

    logic [WW-1:0]  eff_w, a_col;
    logic [HW-1:0]  eff_h, a_row;
    logic [1:0]     a_slot;
    logic           wrap, a_endc, lastr, lastc, drain_last;
    logic [TW-1:0]  total;
    logic [CW-1:0]  line_ra;
    logic [23:0]    merged;
    logic           line_we, mag_we;
    logic           t_en, v_top, v_bot;
    logic [1:0]     s_top, s_mid, s_bot;
    logic [23:0]    c_l, c_m, c_r;
    logic [HW-1:0]  crow;
    logic [WW-1:0]  ccol;
    logic [7:0]     p00, p01, p02, p10, p12, p20, p21, p22;
    logic [9:0]     gxp, gxn, gyp, gyn;
    logic signed [10:0] gx, gy;
    logic signed [21:0] sqx, sqy;
    logic [7:0]     t_try;

    function automatic logic [1:0] inc3(input logic [1:0] s);
        case (s)
            2'd0:    inc3 = 2'd1;
            2'd1:    inc3 = 2'd2;
            default: inc3 = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] dec3(input logic [1:0] s);
        case (s)
            2'd0:    dec3 = 2'd2;
            2'd1:    dec3 = 2'd0;
            default: dec3 = 2'd1;
        endcase
    endfunction

    function automatic logic [7:0] pick(input logic [23:0] col, input logic [1:0] s,
                                        input logic v);
        logic [7:0] b;
        case (s)
            2'd0:    b = col[7:0];
            2'd1:    b = col[15:8];
            default: b = col[23:16];
        endcase
        pick = v ? b : 8'd0;
    endfunction

    // ---- clamped frame size ----
    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            eff_h = HW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_cfg_h);
        end
    end

    assign total = TW'(eff_w) * TW'(eff_h);

    // ---- load position, with a column past the width starting a new row ----
    assign wrap   = r_lcol >= eff_w;
    assign a_row  = wrap ? HW'(r_lrow + 1'b1) : r_lrow;
    assign a_col  = wrap ? '0 : r_lcol;
    assign a_slot = wrap ? inc3(r_slot) : r_slot;
    assign a_endc = ({1'b0, a_col} + 1'b1) >= {1'b0, eff_w};

    assign drain_last = (TW'(r_didx) + 1'b1) >= total;

    assign lastr = ({1'b0, r_row} + 1'b1) >= {1'b0, eff_h};
    assign lastc = ({1'b0, r_col} + 1'b1) >= {1'b0, eff_w};

    // sample merged into its row slot of the column
    always_comb begin
        merged = r_line_q;
        case (r_slotc)
            2'd0:    merged[7:0]   = r_sample;
            2'd1:    merged[15:8]  = r_sample;
            default: merged[23:16] = r_sample;
        endcase
    end

    always_comb begin
        case (r_state)
            S_IDLE:  line_ra = a_col[CW-1:0];
            S_LRD1:  line_ra = CW'(r_col - 1'b1);
            S_LRD2:  line_ra = CW'(r_col - 2'd2);
            default: line_ra = r_col[CW-1:0];
        endcase
    end

    assign line_we = (r_state == S_LRD1);
    assign mag_we  = (r_state == S_WR);

    // ---- window selection per finished pixel ----
    always_comb begin
        t_en  = 1'b0;
        v_top = 1'b0;
        v_bot = 1'b1;
        s_top = dec3(dec3(r_slotc));
        s_mid = dec3(r_slotc);
        s_bot = r_slotc;
        c_l   = r_w0;
        c_m   = r_w1;
        c_r   = r_w2;
        crow  = HW'(r_row - 1'b1);
        ccol  = WW'(r_col - 1'b1);
        case (r_task)
            T_UP_LEFT: begin
                t_en  = (r_row != '0) && (r_col != '0);
                v_top = r_row >= HW'(2);
            end
            T_UP_HERE: begin
                t_en  = (r_row != '0) && lastc;
                v_top = r_row >= HW'(2);
                c_l   = r_w1;
                c_m   = r_w2;
                c_r   = '0;
                ccol  = r_col;
            end
            T_ROW_LEFT: begin
                t_en  = lastr && (r_col != '0);
                v_top = r_row != '0;
                v_bot = 1'b0;
                s_top = dec3(r_slotc);
                s_mid = r_slotc;
                crow  = r_row;
            end
            T_ROW_HERE: begin
                t_en  = lastr && lastc;
                v_top = r_row != '0;
                v_bot = 1'b0;
                s_top = dec3(r_slotc);
                s_mid = r_slotc;
                c_l   = r_w1;
                c_m   = r_w2;
                c_r   = '0;
                crow  = r_row;
                ccol  = r_col;
            end
            default: t_en = 1'b0;
        endcase
    end

    assign p00 = pick(c_l, s_top, v_top);
    assign p01 = pick(c_m, s_top, v_top);
    assign p02 = pick(c_r, s_top, v_top);
    assign p10 = pick(c_l, s_mid, 1'b1);
    assign p12 = pick(c_r, s_mid, 1'b1);
    assign p20 = pick(c_l, s_bot, v_bot);
    assign p21 = pick(c_m, s_bot, v_bot);
    assign p22 = pick(c_r, s_bot, v_bot);

    assign gxp = {2'b0, p00} + {1'b0, p10, 1'b0} + {2'b0, p20};
    assign gxn = {2'b0, p02} + {1'b0, p12, 1'b0} + {2'b0, p22};
    assign gyp = {2'b0, p00} + {1'b0, p01, 1'b0} + {2'b0, p02};
    assign gyn = {2'b0, p20} + {1'b0, p21, 1'b0} + {2'b0, p22};
    assign gx  = $signed({1'b0, gxp}) - $signed({1'b0, gxn});
    assign gy  = $signed({1'b0, gyp}) - $signed({1'b0, gyn});

    assign sqx = 22'(r_gx) * 22'(r_gx);
    assign sqy = 22'(r_gy) * 22'(r_gy);

    // square-root search candidate
    assign t_try = r_v | (8'd1 << r_nb);

    // ---- memories ----
    always_ff @(posedge i_clk) begin
        if (line_we) begin
            line_mem[r_col[CW-1:0]] <= merged;
        end
        r_line_q <= line_mem[line_ra];
    end

    always_ff @(posedge i_clk) begin
        if (mag_we) begin
            mag_mem[r_idx] <= r_mag;
        end
        r_mag_q <= mag_mem[r_didx];
    end

    // ---- control ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_task   <= T_UP_LEFT;
            r_cfg_w  <= sobel_pkg::CFG_RESET;
            r_cfg_h  <= sobel_pkg::CFG_RESET;
            r_lrow   <= '0;
            r_lcol   <= '0;
            r_slot   <= '0;
            r_didx   <= '0;
            r_max    <= '0;
            r_done   <= 1'b0;
            r_out    <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_slotc  <= '0;
            r_idx    <= '0;
            r_mx     <= '0;
            r_mag    <= '0;
            r_sample <= '0;
            r_v      <= '0;
            r_w0     <= '0;
            r_w1     <= '0;
            r_w2     <= '0;
            r_gx     <= '0;
            r_gy     <= '0;
            r_sq     <= '0;
            r_prod   <= '0;
            r_rhs    <= '0;
            r_nb     <= '0;
            r_last   <= 1'b0;
        end else begin
            r_done <= 1'b0;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    sobel_pkg::CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                    sobel_pkg::CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_item.req_type == sobel_pkg::REQ_LOAD) begin
                            r_lrow <= a_row;
                            r_lcol <= a_col;
                            r_slot <= a_slot;
                            if (a_row < eff_h) begin
                                r_row    <= a_row;
                                r_col    <= a_col;
                                r_slotc  <= a_slot;
                                r_sample <= i_item.red_sample;
                                if (a_endc) begin
                                    r_lcol <= '0;
                                    r_lrow <= HW'(a_row + 1'b1);
                                    r_slot <= inc3(a_slot);
                                end else begin
                                    r_lcol <= WW'(a_col + 1'b1);
                                end
                                r_state <= S_LRD1;
                            end
                        end else if (r_lrow >= eff_h) begin
                            r_mx   <= r_max;
                            r_last <= drain_last;
                            if (drain_last) begin
                                r_didx <= '0;
                                r_lrow <= '0;
                                r_lcol <= '0;
                                r_slot <= '0;
                                r_max  <= '0;
                            end else begin
                                r_didx <= AW'(r_didx + 1'b1);
                            end
                            r_state <= S_DRD;
                        end
                    end
                end
                S_LRD1: begin
                    r_w2    <= merged;
                    r_state <= S_LRD2;
                end
                S_LRD2: begin
                    r_w1    <= (r_col >= WW'(1)) ? r_line_q : '0;
                    r_state <= S_LRD3;
                end
                S_LRD3: begin
                    r_w0    <= (r_col >= WW'(2)) ? r_line_q : '0;
                    r_task  <= T_UP_LEFT;
                    r_state <= S_TASK;
                end
                S_TASK: begin
                    if (t_en) begin
                        r_gx    <= gx;
                        r_gy    <= gy;
                        r_idx   <= AW'(TW'(crow) * TW'(eff_w) + TW'(ccol));
                        r_state <= S_SQ;
                    end else if (r_task == T_ROW_HERE) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_task <= t_task'(r_task + 1'b1);
                    end
                end
                S_SQ: begin
                    r_mag   <= MW'(sqx + sqy);
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_mag > r_max) begin
                        r_max <= r_mag;
                    end
                    if (r_task == T_ROW_HERE) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_task  <= t_task'(r_task + 1'b1);
                        r_state <= S_TASK;
                    end
                end
                S_DRD: begin
                    r_rhs   <= RW'(sobel_pkg::NORM_SCALE) * RW'(r_mag_q);
                    r_v     <= '0;
                    r_nb    <= 3'd7;
                    r_state <= S_NSQ;
                end
                S_NSQ: begin
                    r_sq    <= 16'(t_try) * 16'(t_try);
                    r_state <= S_NMUL;
                end
                S_NMUL: begin
                    r_prod  <= RW'(r_sq) * RW'(r_mx);
                    r_state <= S_NCMP;
                end
                S_NCMP: begin
                    if (r_nb == 3'd0) begin
                        if (r_mx == '0) begin
                            r_out.edge_value <= '0;
                        end else begin
                            r_out.edge_value <= (r_prod <= r_rhs) ? t_try : r_v;
                        end
                        r_out.last_pixel <= r_last;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        if (r_prod <= r_rhs) begin
                            r_v <= t_try;
                        end
                        r_nb    <= r_nb - 1'b1;
                        r_state <= S_NSQ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_out;
    assign o_cfg_ready = 1'b1;

    // ---- checks ----
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "result strobe longer than one cycle")
    `ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, r_done, r_state == S_IDLE, "result shown while busy")
    `ASSERT_IMPL(a_slot_ok, i_clk, i_rst_n, 1'b1, (r_slot != 2'd3) && (r_slotc != 2'd3), "row slot out of range")
    `ASSERT_IMPL(a_mag_in_frame, i_clk, i_rst_n, mag_we, TW'(r_idx) < total, "magnitude write outside frame")
    `ASSERT_NEXT(a_max_tracks, i_clk, i_rst_n, mag_we, r_max >= $past(r_mag), "frame maximum missed a value")

endmodule

`default_nettype wire

/* test/tb_sobel_edge_max_normalize.sv */
// Testbench for the Sobel edge block: queued item driver, strobe monitor, predictor.
`timescale 1ns / 1ps

module tb_sobel_edge_max_normalize;

    localparam int MAXW = 1024;
    localparam int MAXH = 1024;
    // worst item is a drain, result strobe in the cycle after its busy time; margin before config
    localparam int SETTLE = 40;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_start;
    logic                          o_busy;
    sobel_pkg::t_in                i_item;
    logic                          o_done;
    sobel_pkg::t_out               o_result;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic                          i_cfg_index;
    logic [sobel_pkg::CFG_DW-1:0]  i_cfg_data;

    sobel_edge_max_normalize i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // ---------------------------------------------------------------
    // Predictor state: line memory, magnitude store, frame counters
    // ---------------------------------------------------------------
    logic [7:0]                    line_mem [0:3*MAXW-1];
    logic [sobel_pkg::MAG_W-1:0]   mag_mem  [int];
    logic [sobel_pkg::MAG_W-1:0]   frame_max;
    int unsigned                   ld_row, ld_col, dr_idx;
    logic [sobel_pkg::CFG_DW-1:0]  width_reg, height_reg;

    sobel_pkg::t_in  pending_items [$];
    sobel_pkg::t_out expected_edges [$];

    int   errors, frames, results_seen;
    bit   calm;       // no idling in the last part of the run
    int   gap;

    function automatic int unsigned clamp_size(logic [sobel_pkg::CFG_DW-1:0] v,
                                               int unsigned top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    function automatic int pixel_at(int r, int c, int unsigned w, int unsigned h);
        if (r < 0 || c < 0 || r >= h || c >= w) return 0;
        return line_mem[(r % 3) * MAXW + c];
    endfunction

    // 3x3 gradient of one pixel, zero outside the frame; vertical kernel 1,2,1
    task automatic gradient_pixel(int r, int c, int unsigned w, int unsigned h);
        int gx, gy, p;
        logic [sobel_pkg::MAG_W-1:0] m;
        gx = 0;
        gy = 0;
        for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
                p = pixel_at(r + dy - 1, c + dx - 1, w, h);
                gx += p * ((dx == 0) ? 1 : (dx == 2) ? -1 : 0) * ((dy == 1) ? 2 : 1);
                gy += p * ((dy == 0) ? 1 : (dy == 2) ? -1 : 0) * ((dx == 1) ? 2 : 1);
            end
        end
        m = sobel_pkg::MAG_W'(gx * gx + gy * gy);
        mag_mem[r * w + c] = m;
        if (m > frame_max) frame_max = m;
    endtask

    // floor(255*sqrt(m/mx)) by bitwise search, exact in integers
    function automatic logic [7:0] scaled_root(logic [sobel_pkg::MAG_W-1:0] m,
                                               logic [sobel_pkg::MAG_W-1:0] mx);
        logic [7:0] v;
        longint unsigned t;
        v = 0;
        if (mx == 0) return 0;
        for (int b = 7; b >= 0; b--) begin
            t = 64'(v | (8'd1 << b));
            if (t * t * mx <= 64'd65025 * m) v[b] = 1'b1;
        end
        return v;
    endfunction

    task automatic predict_item(sobel_pkg::t_in it);
        int unsigned w, h, r, c;
        sobel_pkg::t_out res;
        w = clamp_size(width_reg, MAXW);
        h = clamp_size(height_reg, MAXH);
        if (it.req_type == sobel_pkg::REQ_LOAD) begin
            if (ld_col >= w) begin
                ld_col = 0;
                ld_row++;
            end
            if (ld_row >= h) return;     // frame full: load ignored
            r = ld_row;
            c = ld_col;
            line_mem[(r % 3) * MAXW + c] = it.red_sample;
            if (r >= 1) begin
                if (c >= 1) gradient_pixel(r - 1, c - 1, w, h);
                if (c + 1 >= w) gradient_pixel(r - 1, c, w, h);
            end
            if (r + 1 >= h) begin
                if (c >= 1) gradient_pixel(r, c - 1, w, h);
                if (c + 1 >= w) gradient_pixel(r, c, w, h);
            end
            if (c + 1 >= w) begin
                ld_col = 0;
                ld_row++;
            end else begin
                ld_col++;
            end
            return;
        end
        if (ld_row < h) return;          // drain before frame is full: no result
        res.edge_value = scaled_root(mag_mem.exists(dr_idx) ? mag_mem[dr_idx] : '0,
                                     frame_max);
        res.last_pixel = (dr_idx + 1 >= w * h);
        expected_edges.push_back(res);
        if (res.last_pixel) begin
            dr_idx = 0;
            ld_row = 0;
            ld_col = 0;
            frame_max = 0;
            mag_mem.delete();
        end else begin
            dr_idx = (dr_idx + 1) & 20'hFFFFF;
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: pops pending items, holds while busy, random idle bursts
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            gap     <= 0;
        end else begin
            if (i_start && !o_busy) predict_item(i_item);
            if (i_start && o_busy) begin
                // item not yet taken, keep it on the port
            end else if (gap > 0) begin
                gap     <= gap - 1;
                i_start <= 1'b0;
            end else if (pending_items.size() != 0) begin
                i_item  <= pending_items.pop_front();
                i_start <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) gap <= $urandom_range(1, 8);
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: every strobe must match the oldest expected result
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        sobel_pkg::t_out want;
        if (i_rst_n && o_done) begin
            if (expected_edges.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h/%b", $time,
                         o_result.edge_value, o_result.last_pixel);
                errors++;
            end else begin
                want = expected_edges.pop_front();
                results_seen++;
                if (o_result.edge_value !== want.edge_value) begin
                    $display("%0t: edge_value expected %0d actual %0d", $time,
                             want.edge_value, o_result.edge_value);
                    errors++;
                end
                if (o_result.last_pixel !== want.last_pixel) begin
                    $display("%0t: last_pixel expected %b actual %b", $time,
                             want.last_pixel, o_result.last_pixel);
                    errors++;
                end
            end
        end
    end

    // everything sent and answered, then let the block finish internally
    task automatic wait_idle();
        while (pending_items.size() != 0 || i_start || expected_edges.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [sobel_pkg::CFG_DW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == sobel_pkg::CFG_WIDTH) width_reg = val;
        else height_reg = val;
    endtask

    task automatic set_size(logic [sobel_pkg::CFG_DW-1:0] w,
                            logic [sobel_pkg::CFG_DW-1:0] h);
        wait_idle();
        write_reg(sobel_pkg::CFG_WIDTH, w);
        write_reg(sobel_pkg::CFG_HEIGHT, h);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] sample_for(int pattern, int k, int w);
        case (pattern)
            0: return 8'd0;
            1: return 8'hFF;
            2: return (((k % w) + (k / w)) % 2) ? 8'hFF : 8'h00;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // queue a whole frame; noise = ignored requests mixed in; hold = pause before drain
    task automatic queue_frame(int w, int h, int pattern, bit noise, bit hold);
        sobel_pkg::t_in it;
        for (int k = 0; k < w * h; k++) begin
            if (noise && $urandom_range(0, 7) == 0) begin
                it.req_type   = sobel_pkg::REQ_DRAIN;
                it.red_sample = $urandom_range(0, 255);
                pending_items.push_back(it);
            end
            it.req_type   = sobel_pkg::REQ_LOAD;
            it.red_sample = sample_for(pattern, k, w);
            pending_items.push_back(it);
        end
        if (hold) wait_idle();
        for (int k = 0; k < w * h; k++) begin
            if (noise && $urandom_range(0, 7) == 0) begin
                it.req_type   = sobel_pkg::REQ_LOAD;
                it.red_sample = $urandom_range(0, 255);
                pending_items.push_back(it);
            end
            it.req_type   = sobel_pkg::REQ_DRAIN;
            it.red_sample = $urandom_range(0, 255);
            pending_items.push_back(it);
        end
        frames++;
    endtask

    initial begin
        int w, h, sent;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = sobel_pkg::CFG_WIDTH;
        i_cfg_data  = '0;
        errors = 0;
        frames = 0;
        results_seen = 0;
        calm = 0;
        for (int i = 0; i < 3 * MAXW; i++) line_mem[i] = '0;
        frame_max  = 0;
        ld_row     = 0;
        ld_col     = 0;
        dr_idx     = 0;
        width_reg  = sobel_pkg::CFG_RESET;
        height_reg = sobel_pkg::CFG_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: drains on an empty frame are ignored
        set_size(11'd1, 11'd1);
        begin
            sobel_pkg::t_in it;
            it.req_type   = sobel_pkg::REQ_DRAIN;
            it.red_sample = 8'hA5;
            pending_items.push_back(it);
        end
        queue_frame(1, 1, 1, 0, 0);          // single pixel
        set_size(11'd3, 11'd3);
        queue_frame(3, 3, 0, 0, 0);          // all-zero frame gives zeros
        queue_frame(3, 3, 1, 0, 1);          // flat bright frame, pause before drain
        set_size(11'd0, 11'd4);              // zero width used as one
        queue_frame(1, 4, 2, 1, 0);
        set_size(11'd4, 11'd2);
        queue_frame(4, 2, 2, 1, 0);

        // random small frames, mostly clean, some with ignored requests
        sent = 0;
        while (sent < 680) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
            if (sent > 540) calm = 1;
            set_size(11'(w), 11'(h));
            queue_frame(w, h, $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : 3,
                        $urandom_range(0, 3) == 0, 0);
            sent += 2 * w * h;
        end

        wait_idle();
        $display("Covered %0d frames, %0d results checked, sizes 1..8 plus zero width,",
                 frames, results_seen);
        $display("flat, zero, checkerboard and random content, ignored requests mixed in.");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
